// ----- sv/prt_pkg.sv -----
`timescale 1ns / 1ps

package prt_pkg;

  // Fixed-point settings.
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_STEPS  = 24;
  localparam int RUN_STEPS    = (CORDIC_STEPS > ANGLE_STEPS) ? ANGLE_STEPS : CORDIC_STEPS;
  localparam int STEP_W       = $clog2(RUN_STEPS);

  localparam int COORD_W   = 32;
  localparam int COEF_W    = FRAC_BITS + 2;
  localparam int CORDIC_W  = 34;
  localparam int REG_IDX_W = 8;

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = CORDIC_W'(652032874);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_X  = 8'd0,
    REG_ORIGIN_Y  = 8'd1,
    REG_HEADING   = 8'd2,
    REG_DIRECTION = 8'd3
  } prt_reg_e;

  // Register set seen by the datapath.
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic                      direction;
  } prt_cfg_t;

  // Rotation factors, FRAC_BITS fraction bits.
  typedef struct packed {
    logic signed [COEF_W-1:0] cos_v;
    logic signed [COEF_W-1:0] sin_v;
  } prt_fac_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] prt_atan(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/planar_rigid_transform_core.sv -----
`timescale 1ns / 1ps

// Planar rigid transform: moves Q16.16 points between the world frame and the vehicle
// frame, one point per clock through the offset, multiply, sum, and round and saturate
// stages unless the CORDIC is busy. Stalls on the output back up through the stages
// without loss. A write of the heading register starts a CORDIC that forms cosine and
// sine one step per cycle; until the factors are ready the block accepts neither points
// nor further configuration words. Origin and direction writes take effect at once and
// are meant to be made while no points are in flight.

module planar_rigid_transform_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [prt_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [prt_pkg::COORD_W-1:0] in_x_i,
  input  logic signed [prt_pkg::COORD_W-1:0] in_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [prt_pkg::COORD_W-1:0] out_x_o,
  output logic signed [prt_pkg::COORD_W-1:0] out_y_o
);
  import prt_pkg::*;

  prt_cfg_t cfg_q;
  prt_fac_t fac;
  logic     cordic_busy;
  logic     cfg_write;
  logic     heading_start;
  logic     pipe_in_ready;
  logic     pipe_in_valid;

  assign cfg_ready_o   = !cordic_busy;
  assign cfg_write     = cfg_valid_i && cfg_ready_o;
  assign heading_start = cfg_write && (cfg_index_i == REG_HEADING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x  <= '0;
      cfg_q.origin_y  <= '0;
      cfg_q.direction <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index_i)
        REG_ORIGIN_X:  cfg_q.origin_x  <= cfg_data_i;
        REG_ORIGIN_Y:  cfg_q.origin_y  <= cfg_data_i;
        REG_DIRECTION: cfg_q.direction <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  prt_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (heading_start),
    .heading_i (cfg_data_i[15:0]),
    .busy_o    (cordic_busy),
    .fac_o     (fac)
  );

  assign pipe_in_valid = in_valid_i && !cordic_busy;
  assign in_ready_o    = pipe_in_ready && !cordic_busy;

  prt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fac_i       (fac),
    .in_valid_i  (pipe_in_valid),
    .in_ready_o  (pipe_in_ready),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o)
  );

endmodule

// ----- sv/prt_cordic.sv -----
`timescale 1ns / 1ps

module prt_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [15:0]           heading_i,
  output logic                  busy_o,
  output prt_pkg::prt_fac_t     fac_o
);
  import prt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  localparam logic signed [CORDIC_W-1:0] ONE_F  = CORDIC_W'(1) <<< FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] HALF_F = CORDIC_W'(1) <<< (29 - FRAC_BITS);

  state_e                     state_q;
  logic [STEP_W-1:0]          step_q;
  logic                       flip_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  prt_fac_t                   fac_q;

  logic [15:0]                h_sum;
  logic                       flip_d;
  logic [15:0]                h_fold;
  logic signed [CORDIC_W-1:0] z_start;
  logic signed [CORDIC_W-1:0] dx, dy, at;
  logic signed [CORDIC_W-1:0] x_d, y_d, z_d;
  logic signed [CORDIC_W-1:0] xs, ys, xc, yc;

  // Fold the heading into the right half plane; the far half negates at the end.
  always_comb begin
    h_sum   = heading_i + 16'd16384;
    flip_d  = h_sum[15];
    h_fold  = flip_d ? (heading_i ^ 16'h8000) : heading_i;
    z_start = CORDIC_W'($signed(h_fold)) <<< 16;
  end

  always_comb begin
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = CORDIC_W'(prt_atan(5'(step_q)));
    if (!z_q[CORDIC_W-1]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - at;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + at;
    end
  end

  always_comb begin
    xs = (x_q + HALF_F) >>> (30 - FRAC_BITS);
    ys = (y_q + HALF_F) >>> (30 - FRAC_BITS);
    if (xs > ONE_F) begin
      xc = ONE_F;
    end else if (xs < -ONE_F) begin
      xc = -ONE_F;
    end else begin
      xc = xs;
    end
    if (ys > ONE_F) begin
      yc = ONE_F;
    end else if (ys < -ONE_F) begin
      yc = -ONE_F;
    end else begin
      yc = ys;
    end
    if (flip_q) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      flip_q      <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      fac_q.cos_v <= COEF_W'(ONE_F);
      fac_q.sin_v <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_RUN;
            step_q  <= '0;
            flip_q  <= flip_d;
            x_q     <= GAIN_Q30;
            y_q     <= '0;
            z_q     <= z_start;
          end
        end
        ST_RUN: begin
          x_q <= x_d;
          y_q <= y_d;
          z_q <= z_d;
          if (step_q == STEP_W'(RUN_STEPS - 1)) begin
            state_q <= ST_FIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_FIN: begin
          fac_q.cos_v <= xc[COEF_W-1:0];
          fac_q.sin_v <= yc[COEF_W-1:0];
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign fac_o  = fac_q;

endmodule

// ----- sv/prt_datapath.sv -----
`timescale 1ns / 1ps

module prt_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  prt_pkg::prt_cfg_t                 cfg_i,
  input  prt_pkg::prt_fac_t                 fac_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [prt_pkg::COORD_W-1:0] in_x_i,
  input  logic signed [prt_pkg::COORD_W-1:0] in_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [prt_pkg::COORD_W-1:0] out_x_o,
  output logic signed [prt_pkg::COORD_W-1:0] out_y_o
);
  import prt_pkg::*;

  localparam int AW = COORD_W + 1;
  localparam int PW = AW + COEF_W;
  localparam int SW = PW + 2;
  localparam int RW = SW - FRAC_BITS;

  localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_MAX  = RW'(32'sh7fffffff);
  localparam logic signed [RW-1:0] SAT_MIN  = -RW'(32'sh7fffffff) - RW'(1);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [AW-1:0] a_q, b_q, a_d, b_d;
  logic signed [PW-1:0] pac_q, pbs_q, pbc_q, pas_q;
  logic signed [SW-1:0] sx_q, sy_q, sx_d, sy_d, bx, by;
  logic signed [SW-1:0] rx_full, ry_full;
  logic signed [RW-1:0] rx, ry;
  logic signed [COORD_W-1:0] ox_q, oy_q, ox_d, oy_d;

  // Each stage moves on when its successor is empty or moving too.
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: offset into the vehicle frame, or pass the point as is.
  always_comb begin
    if (!cfg_i.direction) begin
      a_d = AW'(in_x_i) - AW'(cfg_i.origin_x);
      b_d = AW'(in_y_i) - AW'(cfg_i.origin_y);
    end else begin
      a_d = AW'(in_x_i);
      b_d = AW'(in_y_i);
    end
  end

  // Stage 3: combine products, with the origin added for vehicle to world.
  always_comb begin
    bx = SW'(cfg_i.origin_x) <<< FRAC_BITS;
    by = SW'(cfg_i.origin_y) <<< FRAC_BITS;
    if (!cfg_i.direction) begin
      sx_d = SW'(pac_q) + SW'(pbs_q);
      sy_d = SW'(pbc_q) - SW'(pas_q);
    end else begin
      sx_d = bx + SW'(pac_q) - SW'(pbs_q);
      sy_d = by + SW'(pas_q) + SW'(pbc_q);
    end
  end

  // Stage 4: round half up, then saturate to 32 bits.
  always_comb begin
    rx_full = (sx_q + HALF_LSB) >>> FRAC_BITS;
    ry_full = (sy_q + HALF_LSB) >>> FRAC_BITS;
    rx      = rx_full[RW-1:0];
    ry      = ry_full[RW-1:0];
    if (rx > SAT_MAX) begin
      ox_d = COORD_W'(SAT_MAX);
    end else if (rx < SAT_MIN) begin
      ox_d = COORD_W'(SAT_MIN);
    end else begin
      ox_d = rx[COORD_W-1:0];
    end
    if (ry > SAT_MAX) begin
      oy_d = COORD_W'(SAT_MAX);
    end else if (ry < SAT_MIN) begin
      oy_d = COORD_W'(SAT_MIN);
    end else begin
      oy_d = ry[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
    if (rdy2 && v1_q) begin
      pac_q <= a_q * fac_i.cos_v;
      pbs_q <= b_q * fac_i.sin_v;
      pbc_q <= b_q * fac_i.cos_v;
      pas_q <= a_q * fac_i.sin_v;
    end
    if (rdy3 && v2_q) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
    if (rdy4 && v3_q) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;

endmodule

// ----- sv/prt_checker.sv -----
`timescale 1ns / 1ps

module prt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [prt_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [prt_pkg::COORD_W-1:0] out_x_o,
  input logic signed [prt_pkg::COORD_W-1:0] out_y_o
);
  import prt_pkg::*;

  logic heading_write;
  assign heading_write = cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_HEADING);

  // A stalled output word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o))
    else $error("output word changed or dropped while stalled");

  // While the factors are being formed, no point and no word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    heading_write |=> !in_ready_o && !cfg_ready_o)
    else $error("port ready while heading factors are being formed");

  // The pipeline is four deep: no output word appears too soon after reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("output word appeared too soon after reset");

  // With the output drained and kept free, a point that goes in comes out after passing every stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && out_ready_i
      ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("point did not reach the output after four cycles");

endmodule

bind planar_rigid_transform_core prt_checker u_prt_checker (.*);
